@@ rtl/core/spq_pkg.sv @@
// Package for the sorted priority queue: sizes, opcodes, entry and cell-control types.
// Used by spq_cell and sorted_priority_queue_keyed_update; depends on nothing.
package spq_pkg;

  localparam int Depth    = 32;
  localparam int IdxW     = $clog2(Depth);
  localparam int CntW     = $clog2(Depth + 1);
  localparam int TagW     = 32;
  localparam int PrioW    = 16;
  localparam int TimeW    = 64;
  localparam int OpW      = 3;
  localparam int InDataW  = 120;
  localparam int OutDataW = 112;

  localparam logic [OpW-1:0] OP_ADMIT  = 3'd0;
  localparam logic [OpW-1:0] OP_POP    = 3'd1;
  localparam logic [OpW-1:0] OP_PEEK   = 3'd2;
  localparam logic [OpW-1:0] OP_REMOVE = 3'd3;
  localparam logic [OpW-1:0] OP_UPDATE = 3'd4;
  localparam logic [OpW-1:0] OP_LIST   = 3'd5;

  typedef struct packed {
    logic [TagW-1:0]         tag;
    logic signed [PrioW-1:0] prio;
    logic [TimeW-1:0]        tstamp;
  } entry_t;

  // What one cell does at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_act_t;

  typedef struct packed {
    cell_act_t act;
    entry_t    load;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REINS,
    ST_LIST
  } state_t;

  // True if stored entry e has a key equal to or better than (p, t).
  function automatic logic at_least(entry_t e, logic signed [PrioW-1:0] p,
                                    logic [TimeW-1:0] t);
    logic r;
    if (e.prio != p) r = (e.prio > p);
    else r = (e.tstamp <= t);
    return r;
  endfunction

endpackage

@@ rtl/core/spq_cell.sv @@
// One slot of the sorted shift chain: holds an entry, takes it from either neighbor or a load.
// Depends on spq_pkg.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t    prev_entry,
  input  spq_pkg::entry_t    next_entry,
  output spq_pkg::entry_t    entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // Select the next content of the slot.
  always_comb begin
    case (ctl.act)
      spq_pkg::CELL_LOAD:      entry_nxt = ctl.load;
      spq_pkg::CELL_FROM_PREV: entry_nxt = prev_entry;
      spq_pkg::CELL_FROM_NEXT: entry_nxt = next_entry;
      default:                 entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

@@ rtl/core/sorted_priority_queue_keyed_update.sv @@
// Top level of the sorted priority queue; a row of spq_cell slots plus the control.
// Depends on spq_pkg and spq_cell.
//
// A sorted queue of up to 32 entries held in a row of slots, best key at slot 0
// (higher priority first, then earlier time, equal keys in arrival order).
// Admit, pop, peek and remove each finish in the accepting cycle: every slot
// compares itself with the request in parallel, and for admit, pop and remove
// the row shifts by one place. Update removes the matching entry, then admits
// it with its new priority from a reinsert state. List reads the slots one per
// cycle while the receiver takes them, from a list state entered on accept;
// the input is held off until the last listed transaction has been taken. The
// single output register lets the next input be accepted in the same cycle in
// which a waiting pop or peek result is taken.
module sorted_priority_queue_keyed_update (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [2:0] op, [34:3] tag_in, [50:35] prio_in, [114:51] time_in, rest zero
  input  logic [spq_pkg::InDataW-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [31:0] tag_out, [47:32] prio_out, [111:48] time_out
  output logic [spq_pkg::OutDataW-1:0] out_tdata,
  output logic                         out_tlast
);

  localparam int D = spq_pkg::Depth;

  // Input fields.
  logic [spq_pkg::OpW-1:0]          op;
  spq_pkg::entry_t                  req;
  assign op         = in_tdata[2:0];
  assign req.tag    = in_tdata[34:3];
  assign req.prio   = in_tdata[50:35];
  assign req.tstamp = in_tdata[114:51];

  spq_pkg::state_t                  state_r, state_nxt;
  logic [spq_pkg::CntW-1:0]         count_r, count_nxt;
  logic [spq_pkg::IdxW-1:0]         lidx_r, lidx_nxt;
  spq_pkg::entry_t                  pend_r, pend_nxt;
  logic                             ovalid_r, ovalid_nxt;
  logic                             olast_r, olast_nxt;
  spq_pkg::entry_t                  odata_r, odata_nxt;

  spq_pkg::entry_t                  ent [D];
  spq_pkg::cell_ctl_t               ctl [D];
  logic [D-1:0]                     ge;
  logic [D-1:0]                     mt;
  logic [D-1:0]                     before_m;
  logic                             found;
  logic                             accept;
  logic                             out_free;
  spq_pkg::entry_t                  ins;
  logic                             do_ins, do_del;
  logic [D-1:0]                     del_after;

  // The row of slots; the ends see their own content as the outer neighbor.
  for (genvar g = 0; g < D; g++) begin : g_cell
    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .prev_entry ((g == 0) ? ent[0] : ent[(g == 0) ? 0 : g-1]),
      .next_entry ((g == D-1) ? ent[D-1] : ent[(g == D-1) ? D-1 : g+1]),
      .entry      (ent[g])
    );
  end

  // Insert key: a pending update uses the held entry.
  assign ins = (state_r == spq_pkg::ST_REINS) ? pend_r : req;

  // Per-slot compares against the insert key and the match key.
  always_comb begin
    for (int i = 0; i < D; i++) begin
      ge[i] = (i < count_r) && spq_pkg::at_least(ent[i], ins.prio, ins.tstamp);
      mt[i] = (i < count_r) && (ent[i].tag == req.tag) && (ent[i].tstamp == req.tstamp);
    end
    before_m[0] = 1'b0;
    for (int i = 1; i < D; i++) before_m[i] = before_m[i-1] | mt[i-1];
    found = |mt;
  end

  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (state_r == spq_pkg::ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  // Control: chooses the row operation, output and next state.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    lidx_nxt   = lidx_r;
    pend_nxt   = pend_r;
    ovalid_nxt = ovalid_r && !out_tready;
    olast_nxt  = olast_r;
    odata_nxt  = odata_r;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    del_after  = '0;
    case (state_r)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            spq_pkg::OP_ADMIT: begin
              if (count_r < D) begin
                do_ins    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
              if (count_r != '0) begin
                ovalid_nxt = 1'b1;
                olast_nxt  = 1'b1;
                odata_nxt  = ent[0];
                if (op == spq_pkg::OP_POP) begin
                  do_del    = 1'b1;
                  del_after = {D{1'b1}};
                  count_nxt = count_r - 1'b1;
                end
              end
            end
            spq_pkg::OP_REMOVE, spq_pkg::OP_UPDATE: begin
              if (found) begin
                // The first matching slot and every slot behind it shift forward.
                do_del    = 1'b1;
                del_after = before_m | mt;
                count_nxt = count_r - 1'b1;
                if (op == spq_pkg::OP_UPDATE) begin
                  pend_nxt  = req;
                  state_nxt = spq_pkg::ST_REINS;
                end
              end
            end
            spq_pkg::OP_LIST: begin
              if (count_r != '0) begin
                lidx_nxt  = '0;
                state_nxt = spq_pkg::ST_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      spq_pkg::ST_REINS: begin
        do_ins    = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = spq_pkg::ST_IDLE;
      end
      spq_pkg::ST_LIST: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = ent[lidx_r];
          olast_nxt  = ({1'b0, lidx_r} + 1'b1 == count_r);
          if (olast_nxt) state_nxt = spq_pkg::ST_IDLE;
          else lidx_nxt = lidx_r + 1'b1;
        end
      end
      default: state_nxt = spq_pkg::ST_IDLE;
    endcase
  end

  // Per-slot actions for insert and delete shifts.
  always_comb begin
    for (int i = 0; i < D; i++) begin
      ctl[i].act  = spq_pkg::CELL_HOLD;
      ctl[i].load = ins;
      if (do_ins && !ge[i]) begin
        if (i == 0 || ge[(i == 0) ? 0 : i-1]) ctl[i].act = spq_pkg::CELL_LOAD;
        else ctl[i].act = spq_pkg::CELL_FROM_PREV;
      end else if (do_del && del_after[i] && i != D-1) begin
        ctl[i].act = spq_pkg::CELL_FROM_NEXT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= spq_pkg::ST_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lidx_r  <= lidx_nxt;
    pend_r  <= pend_nxt;
    olast_r <= olast_nxt;
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {odata_r.tstamp, odata_r.prio, odata_r.tag};

endmodule
